// File: hdl/rtdtemp_pkg.sv
package rtdtemp_pkg;

    localparam int NEWTON_STEPS = 12;
    localparam int STEP_W       = $clog2(NEWTON_STEPS + 1);

    localparam int DIV_BITS     = 54;
    localparam int DIV_CNT_W    = $clog2(DIV_BITS + 1);
    localparam int SQRT_DIGITS  = 22;
    localparam int SQRT_CNT_W   = $clog2(SQRT_DIGITS + 1);

    localparam logic [23:0]        SCALE_RESET  = 24'd59354;
    localparam logic signed [31:0] OHM100_Q16   = 32'sd6553600;
    localparam logic [22:0]        A1_Q23       = 23'd3278520;
    localparam logic signed [51:0] A1_SQ_Q46    = 52'sd3278520 * 52'sd3278520;
    localparam logic signed [45:0] FOUR_B1_Q30  = 46'sd248034;
    localparam logic signed [45:0] A1_Q30       = 46'sd419650517;
    localparam logic [28:0]        A1_Q30_DVS   = 29'd419650517;
    localparam logic signed [32:0] B1_Q40       = -33'sd63496797;
    localparam logic signed [45:0] TWO_B1_Q40   = -46'sd126993594;
    localparam logic signed [32:0] C1_Q50       = -33'sd470964;
    localparam logic signed [19:0] G_BASE       = 20'sd25613;
    localparam logic signed [26:0] T_LIMIT_Q16  = 27'sd33554432;
    localparam logic signed [18:0] T_HIGH_Q8    = 19'sd217600;
    localparam logic signed [18:0] T_LOW_Q8     = -19'sd51200;

    typedef enum logic [2:0] {
        STAT_UPPER    = 3'd0,
        STAT_NEWTON   = 3'd1,
        STAT_NONPOS   = 3'd2,
        STAT_CLAMP_HI = 3'd3,
        STAT_CLAMP_LO = 3'd4,
        STAT_NO_ROOT  = 3'd5
    } status_t;

endpackage

// File: hdl/rtd_code_to_temperature_core.sv
// A nonpositive resistance ends after the resistance multiply; above 100 ohm a square
// root and a division follow unless the discriminant is negative; below 100 ohm up to
// twelve Newton steps run, each with eight 8-bit-per-cycle multiplier passes and a bit-serial divide.
// Throughput: one request at a time; the next is taken once the previous one is done.
// Reset: rst_n is asynchronous and active low; it clears control state and loads
// the default ohms-per-code scale.
module rtd_code_to_temperature_core
    import rtdtemp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // adc_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // resistance_q16, temperature_q8, status, zero pad
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_COLLECT, S_SQRT, S_SQEND, S_DIV, S_DIVEND, S_FINAL,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_R, OP_DISC, OP_T2, OP_T3, OP_W, OP_FA, OP_FB, OP_FC, OP_GB, OP_GC
    } op_t;

    typedef enum logic [1:0] {
        DV_UP, DV_INIT, DV_STEP
    } div_op_t;

    state_t  state_reg;
    op_t     op_reg;
    div_op_t dop_reg;

    logic [23:0]        scale_reg;
    logic signed [15:0] code_reg;
    logic signed [31:0] r_reg;
    logic signed [32:0] d_reg;
    logic signed [26:0] t_reg;
    logic signed [35:0] t2_reg;
    logic signed [44:0] t3_reg;
    logic signed [42:0] w_reg;
    logic signed [27:0] facc_reg;
    logic signed [27:0] f_reg;
    logic signed [19:0] gacc_reg;
    logic [STEP_W-1:0]  step_reg;
    logic signed [18:0] temp_reg;
    status_t            status_reg;

    logic [44:0] a_mag_reg;
    logic [31:0] b_reg;
    logic        mul_neg_reg;
    logic [53:0] hi_reg;
    logic [31:0] lo_reg;
    logic [1:0]  mul_cnt_reg;

    logic [43:0]           rad_reg;
    logic [23:0]           sq_rem_reg;
    logic [21:0]           root_reg;
    logic [SQRT_CNT_W-1:0] sq_cnt_reg;

    logic [53:0]          nq_reg;
    logic [28:0]          dv_rem_reg;
    logic [28:0]          dvs_reg;
    logic [DIV_CNT_W-1:0] dv_cnt_reg;

    logic               m_valid_reg;
    logic [31:0]        res_out_reg;
    logic [18:0]        temp_out_reg;
    status_t            status_out_reg;

    logic signed [45:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [45:0] mul_a_abs;
    logic signed [32:0] mul_b_abs;
    logic [53:0]        mul_sum;
    logic signed [86:0] prod_s;
    logic signed [31:0] r_new;
    logic signed [51:0] disc;
    logic signed [47:0] v_full;
    logic signed [35:0] v_val;
    logic signed [27:0] f_new;
    logic signed [19:0] g_new;
    logic [27:0]        f_abs;
    logic [32:0]        d_abs;
    logic [25:0]        sq_trial;
    logic [25:0]        sq_rem_sh;
    logic [23:0]        den;
    logic [29:0]        dv_rem_sh;
    logic signed [55:0] q_signed;
    logic signed [55:0] t_new;
    logic signed [27:0] t_round;
    logic signed [19:0] tq8;

    always_comb
    begin
        case (op_reg)
            OP_R:    begin mul_a = 46'(code_reg);      mul_b = $signed({9'b0, scale_reg}); end
            OP_DISC: begin mul_a = FOUR_B1_Q30;        mul_b = d_reg; end
            OP_T2:   begin mul_a = 46'(t_reg);         mul_b = 33'(t_reg); end
            OP_T3:   begin mul_a = 46'(t2_reg);        mul_b = 33'(t_reg); end
            OP_W:    begin mul_a = 46'(t3_reg >>> 12); mul_b = 33'(t_reg) - 33'(OHM100_Q16); end
            OP_FA:   begin mul_a = A1_Q30;             mul_b = 33'(t_reg); end
            OP_FB:   begin mul_a = 46'(t2_reg);        mul_b = B1_Q40; end
            OP_FC:   begin mul_a = 46'(w_reg);         mul_b = C1_Q50; end
            OP_GB:   begin mul_a = TWO_B1_Q40;         mul_b = 33'(t_reg); end
            OP_GC:   begin mul_a = 46'(v_val);         mul_b = C1_Q50; end
            default: begin mul_a = '0;                 mul_b = '0; end
        endcase
    end

    assign mul_a_abs = mul_a[45] ? -mul_a : mul_a;
    assign mul_b_abs = mul_b[32] ? -mul_b : mul_b;
    assign mul_sum   = hi_reg + 54'(a_mag_reg * b_reg[7:0]);
    assign prod_s    = mul_neg_reg ? -$signed({1'b0, hi_reg, lo_reg})
                                   : $signed({1'b0, hi_reg, lo_reg});

    assign r_new   = $signed(prod_s[39:8]);
    assign disc    = A1_SQ_Q46 - 52'(prod_s);
    assign v_full  = (48'(t3_reg) <<< 2) - 48'(t2_reg) * 48'sd300;
    assign v_val   = 36'(v_full >>> 12);
    assign f_new   = facc_reg + $signed(prod_s[65:38]) - 28'(d_reg);
    assign g_new   = gacc_reg + $signed(prod_s[57:38]);
    assign f_abs   = f_reg[27] ? 28'(-f_reg) : 28'(f_reg);
    assign d_abs   = 33'(-d_reg);

    assign sq_rem_sh = {sq_rem_reg, rad_reg[43:42]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign den       = 24'(A1_Q23) + 24'(root_reg);
    assign dv_rem_sh = {dv_rem_reg, nq_reg[53]};

    assign q_signed = f_reg[27] ? -$signed({2'b00, nq_reg}) : $signed({2'b00, nq_reg});
    assign t_new    = 56'(t_reg) - q_signed;
    assign t_round  = 28'(t_reg) + 28'sd128;
    assign tq8      = 20'(t_round >>> 8);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, status_out_reg, temp_out_reg, res_out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_R;
            dop_reg        <= DV_UP;
            scale_reg      <= SCALE_RESET;
            m_valid_reg    <= 1'b0;
            mul_cnt_reg    <= '0;
            sq_cnt_reg     <= '0;
            dv_cnt_reg     <= '0;
            step_reg       <= '0;
            status_reg     <= STAT_UPPER;
            status_out_reg <= STAT_UPPER;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        code_reg  <= $signed(s_tdata);
                        op_reg    <= OP_R;
                        state_reg <= S_LOAD;
                    end
                end

                S_LOAD:
                begin
                    a_mag_reg   <= mul_a_abs[44:0];
                    b_reg       <= mul_b_abs[31:0];
                    mul_neg_reg <= mul_a[45] ^ mul_b[32];
                    hi_reg      <= '0;
                    lo_reg      <= '0;
                    mul_cnt_reg <= 2'd3;
                    state_reg   <= S_MUL;
                end

                S_MUL:
                begin
                    hi_reg      <= {8'b0, mul_sum[53:8]};
                    lo_reg      <= {mul_sum[7:0], lo_reg[31:8]};
                    b_reg       <= {8'b0, b_reg[31:8]};
                    mul_cnt_reg <= mul_cnt_reg - 2'd1;
                    if (mul_cnt_reg == 2'd0)
                    begin
                        state_reg <= S_COLLECT;
                    end
                end

                S_COLLECT:
                begin
                    case (op_reg)
                        OP_R:
                        begin
                            r_reg <= r_new;
                            d_reg <= 33'(r_new) - 33'(OHM100_Q16);
                            if (r_new <= 32'sd0)
                            begin
                                temp_reg   <= T_LOW_Q8;
                                status_reg <= STAT_NONPOS;
                                state_reg  <= S_DONE;
                            end
                            else if (r_new >= OHM100_Q16)
                            begin
                                op_reg    <= OP_DISC;
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                nq_reg     <= 54'(d_abs[22:0]) << 30;
                                dvs_reg    <= A1_Q30_DVS;
                                dv_rem_reg <= '0;
                                dv_cnt_reg <= DIV_CNT_W'(DIV_BITS);
                                dop_reg    <= DV_INIT;
                                state_reg  <= S_DIV;
                            end
                        end
                        OP_DISC:
                        begin
                            if (disc < 52'sd0)
                            begin
                                temp_reg   <= '0;
                                status_reg <= STAT_NO_ROOT;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                rad_reg    <= disc[43:0];
                                sq_rem_reg <= '0;
                                root_reg   <= '0;
                                sq_cnt_reg <= SQRT_CNT_W'(SQRT_DIGITS);
                                state_reg  <= S_SQRT;
                            end
                        end
                        OP_T2:
                        begin
                            t2_reg    <= $signed(prod_s[51:16]);
                            op_reg    <= OP_T3;
                            state_reg <= S_LOAD;
                        end
                        OP_T3:
                        begin
                            t3_reg    <= $signed(prod_s[60:16]);
                            op_reg    <= OP_W;
                            state_reg <= S_LOAD;
                        end
                        OP_W:
                        begin
                            w_reg     <= $signed(prod_s[58:16]);
                            op_reg    <= OP_FA;
                            state_reg <= S_LOAD;
                        end
                        OP_FA:
                        begin
                            facc_reg  <= $signed(prod_s[57:30]);
                            op_reg    <= OP_FB;
                            state_reg <= S_LOAD;
                        end
                        OP_FB:
                        begin
                            facc_reg  <= facc_reg + $signed(prod_s[67:40]);
                            op_reg    <= OP_FC;
                            state_reg <= S_LOAD;
                        end
                        OP_FC:
                        begin
                            f_reg     <= f_new;
                            op_reg    <= OP_GB;
                            state_reg <= S_LOAD;
                        end
                        OP_GB:
                        begin
                            gacc_reg  <= G_BASE + $signed(prod_s[59:40]);
                            op_reg    <= OP_GC;
                            state_reg <= S_LOAD;
                        end
                        OP_GC:
                        begin
                            if (g_new <= 20'sd0)
                            begin
                                state_reg <= S_FINAL;
                            end
                            else
                            begin
                                nq_reg     <= 54'(f_abs) << 16;
                                dvs_reg    <= 29'(g_new[18:0]);
                                dv_rem_reg <= '0;
                                dv_cnt_reg <= DIV_CNT_W'(DIV_BITS);
                                dop_reg    <= DV_STEP;
                                state_reg  <= S_DIV;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_SQRT:
                begin
                    rad_reg <= {rad_reg[41:0], 2'b00};
                    if (sq_rem_sh >= sq_trial)
                    begin
                        sq_rem_reg <= 24'(sq_rem_sh - sq_trial);
                        root_reg   <= {root_reg[20:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= sq_rem_sh[23:0];
                        root_reg   <= {root_reg[20:0], 1'b0};
                    end
                    sq_cnt_reg <= sq_cnt_reg - SQRT_CNT_W'(1);
                    if (sq_cnt_reg == SQRT_CNT_W'(1))
                    begin
                        state_reg <= S_SQEND;
                    end
                end

                S_SQEND:
                begin
                    nq_reg     <= (54'(d_reg[31:0]) << 16) + 54'(den >> 1);
                    dvs_reg    <= 29'(den);
                    dv_rem_reg <= '0;
                    dv_cnt_reg <= DIV_CNT_W'(DIV_BITS);
                    dop_reg    <= DV_UP;
                    state_reg  <= S_DIV;
                end

                S_DIV:
                begin
                    if (dv_rem_sh >= {1'b0, dvs_reg})
                    begin
                        dv_rem_reg <= 29'(dv_rem_sh - {1'b0, dvs_reg});
                        nq_reg     <= {nq_reg[52:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg <= dv_rem_sh[28:0];
                        nq_reg     <= {nq_reg[52:0], 1'b0};
                    end
                    dv_cnt_reg <= dv_cnt_reg - DIV_CNT_W'(1);
                    if (dv_cnt_reg == DIV_CNT_W'(1))
                    begin
                        state_reg <= S_DIVEND;
                    end
                end

                S_DIVEND:
                begin
                    case (dop_reg)
                        DV_UP:
                        begin
                            if (nq_reg > 54'(T_HIGH_Q8))
                            begin
                                temp_reg   <= T_HIGH_Q8;
                                status_reg <= STAT_CLAMP_HI;
                            end
                            else
                            begin
                                temp_reg   <= $signed(nq_reg[18:0]);
                                status_reg <= STAT_UPPER;
                            end
                            state_reg <= S_DONE;
                        end
                        DV_INIT:
                        begin
                            t_reg     <= $signed(27'(0) - 27'(nq_reg[25:0]));
                            step_reg  <= '0;
                            op_reg    <= OP_T2;
                            state_reg <= S_LOAD;
                        end
                        DV_STEP:
                        begin
                            if (t_new > 56'(T_LIMIT_Q16))
                            begin
                                t_reg <= T_LIMIT_Q16;
                            end
                            else if (t_new < -56'(T_LIMIT_Q16))
                            begin
                                t_reg <= -T_LIMIT_Q16;
                            end
                            else
                            begin
                                t_reg <= $signed(t_new[26:0]);
                            end
                            step_reg <= step_reg + STEP_W'(1);
                            if (step_reg == STEP_W'(NEWTON_STEPS - 1))
                            begin
                                state_reg <= S_FINAL;
                            end
                            else
                            begin
                                op_reg    <= OP_T2;
                                state_reg <= S_LOAD;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_FINAL:
                begin
                    if (tq8 < 20'(T_LOW_Q8))
                    begin
                        temp_reg   <= T_LOW_Q8;
                        status_reg <= STAT_CLAMP_LO;
                    end
                    else
                    begin
                        temp_reg   <= $signed(tq8[18:0]);
                        status_reg <= STAT_NEWTON;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        res_out_reg    <= r_reg;
                        temp_out_reg   <= temp_reg;
                        status_out_reg <= status_reg;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/rtd_code_to_temperature_checker.sv
module rtd_code_to_temperature_checker
    import rtdtemp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint R0_Q16    = 64'sd6553600;
    localparam longint A1_Q23_L  = 64'sd3278520;
    localparam longint FOUR_B1_L = 64'sd248034;
    localparam longint A1_Q30_L  = 64'sd419650517;
    localparam longint B1_Q40_L  = -64'sd63496797;
    localparam longint C1_Q50_L  = -64'sd470964;
    localparam longint T_LIM_L   = 64'sd33554432;
    localparam longint T_HI_L    = 64'sd217600;
    localparam longint T_LO_L    = -64'sd51200;

    typedef struct packed {
        logic signed [31:0] ohms;
        logic signed [18:0] temp;
        status_t            stat;
    } reading_t;

    logic [23:0] scale_copy;
    reading_t    readings_due[$];

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic reading_t convert_code(input logic signed [15:0] code,
                                              input logic [23:0] scale);
        reading_t rd;
        longint r, d, disc, den, t, t2, t3, w, f, v, g, tq8;
        r = (longint'(code) * longint'(scale)) >>> 8;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        rd.ohms = r[31:0];
        d = r - R0_Q16;
        if (r <= 0)
        begin
            t = T_LO_L;
            rd.stat = STAT_NONPOS;
        end
        else if (r >= R0_Q16)
        begin
            disc = A1_Q23_L * A1_Q23_L - FOUR_B1_L * d;
            if (disc < 0)
            begin
                t = 0;
                rd.stat = STAT_NO_ROOT;
            end
            else
            begin
                den = A1_Q23_L + longint'(root_floor(disc));
                t = (d * 65536 + den / 2) / den;
                rd.stat = STAT_UPPER;
                if (t > T_HI_L)
                begin
                    t = T_HI_L;
                    rd.stat = STAT_CLAMP_HI;
                end
            end
        end
        else
        begin
            t = (d * (64'sd1 << 30)) / A1_Q30_L;
            for (int i = 0; i < NEWTON_STEPS; i++)
            begin
                t2 = (t * t) >>> 16;
                t3 = (t2 * t) >>> 16;
                w = ((t - R0_Q16) * (t3 >>> 12)) >>> 16;
                f = ((A1_Q30_L * t) >>> 30) + ((B1_Q40_L * t2) >>> 40)
                    + ((C1_Q50_L * w) >>> 38) - d;
                v = (4 * t3 - 300 * t2) >>> 12;
                g = A1_Q30_L / 16384 + ((2 * B1_Q40_L * t) >>> 40)
                    + ((C1_Q50_L * v) >>> 38);
                if (g <= 0)
                    break;
                t = t - (f * 65536) / g;
                if (t > T_LIM_L)
                    t = T_LIM_L;
                if (t < -T_LIM_L)
                    t = -T_LIM_L;
            end
            tq8 = (t + 128) >>> 8;
            rd.stat = STAT_NEWTON;
            t = tq8;
            if (tq8 < T_LO_L)
            begin
                t = T_LO_L;
                rd.stat = STAT_CLAMP_LO;
            end
        end
        rd.temp = t[18:0];
        return rd;
    endfunction

    assign pending = readings_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t exp_rd;
        int       fails;
        if (!rst_n)
        begin
            scale_copy <= SCALE_RESET;
            errors <= 0;
        end
        else
        begin
            fails = 0;
            if (cfg_wr_en)
                scale_copy <= cfg_wr_data;
            if (s_tvalid && s_tready)
                readings_due.push_back(convert_code(s_tdata, scale_copy));
            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    fails = fails + 1;
                end
                else
                begin
                    exp_rd = readings_due.pop_front();
                    if (m_tdata[31:0] !== exp_rd.ohms)
                    begin
                        $error("resistance_q16 expected %0d actual %0d",
                               exp_rd.ohms, $signed(m_tdata[31:0]));
                        fails = fails + 1;
                    end
                    if (m_tdata[50:32] !== exp_rd.temp)
                    begin
                        $error("temperature_q8 expected %0d actual %0d",
                               exp_rd.temp, $signed(m_tdata[50:32]));
                        fails = fails + 1;
                    end
                    if (m_tdata[53:51] !== exp_rd.stat)
                    begin
                        $error("status expected %0d actual %0d",
                               exp_rd.stat, m_tdata[53:51]);
                        fails = fails + 1;
                    end
                end
            end
            errors <= errors + fails;
        end
    end

endmodule

// File: dv/tb_top.sv
module tb_top
    import rtdtemp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          steady_sink = 1'b0;

    always #6 clk = ~clk;

    rtd_code_to_temperature_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rtd_code_to_temperature_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    function automatic int draw_gap(input bit steady);
        if (steady)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic send_code(input logic [15:0] code, input bit steady);
        int gap;
        gap = draw_gap(steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= code;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_scale(input logic [23:0] scale);
        cfg_wr_data <= scale;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // The sink alternates between random stalls and stretches of steady acceptance.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                steady_sink = ~steady_sink;
            gap = draw_gap(steady_sink);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        logic [23:0] scales[7];
        logic [15:0] directed[$];
        logic [15:0] code;
        bit          steady;
        scales = '{SCALE_RESET, 24'd0, 24'hFFFFFF, 24'd204800, 24'd450000,
                   24'd30000, 24'd0};
        scales[6] = 24'($urandom_range(1, 24'hFFFFFF));
        directed = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 16'd28267,
                     16'd28266, 16'h5555, 16'hAAAA, 16'd5000, 16'd1000, 16'd20000};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_code(directed[i], 1'b0);
        drain_requests();
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                write_scale(scales[ph]);
                send_code(16'h7FFF, 1'b0);
                send_code(16'd1, 1'b0);
                send_code(16'd16384, 1'b0);
            end
            steady = 1'b0;
            for (int n = 0; n < 160; n++)
            begin
                if ($urandom_range(0, 30) == 0)
                    steady = ~steady;
                if ($urandom_range(0, 3) == 0)
                    code = 16'($urandom);
                else
                    code = 16'($urandom_range(1, 32767));
                send_code(code, steady);
            end
            drain_requests();
        end
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: files.f
hdl/rtdtemp_pkg.sv
hdl/rtd_code_to_temperature_core.sv
dv/rtd_code_to_temperature_checker.sv
dv/tb_top.sv
